### rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

  localparam int MaxTasks = 16;
  localparam int IdxW     = $clog2(MaxTasks);
  localparam int SlotW    = 4;
  localparam int CountW   = 5;
  localparam int IdW      = 8;
  localparam int PrioW    = 8;
  localparam int TimeW    = 16;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [TimeW-1:0]  time_t;
  typedef logic [IdW-1:0]    id_t;
  typedef logic [PrioW-1:0]  prio_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [0:0] {
    CmdLoad = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [SlotW-1:0]       slot;
    id_t                    task_id;
    time_t                  arrival_time;
    time_t                  burst_length;
    prio_t                  task_priority;
  } in_word_t;

  typedef struct packed {
    time_t tick_time;
    logic  ran;
    id_t   run_id;
    logic  completed;
    time_t finish_at;
    time_t turnaround;
    time_t waiting;
    logic  all_done;
  } out_word_t;

  // table update request from the top level
  typedef struct packed {
    logic  load;
    idx_t  load_idx;
    id_t   id;
    time_t arrival;
    time_t burst;
    prio_t prio;
    logic  dec;
    idx_t  dec_idx;
  } tbl_wr_t;

  // selection result
  typedef struct packed {
    logic ran;
    idx_t idx;
    logic all_done;
  } pick_t;

endpackage

### rtl/pps_if.sv
// Valid/ready channel interfaces for task words, result words and config writes.
interface pps_in_if;
  logic              valid;
  logic              ready;
  pps_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pps_out_if;
  logic               valid;
  logic               ready;
  pps_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pps_cfg_if;
  logic            valid;
  logic            ready;
  pps_pkg::count_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/pps_table.sv
// Task table: per-slot id, arrival, burst, priority and remaining work.
module pps_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pps_pkg::tbl_wr_t wr_i,
  output pps_pkg::id_t     ids_o        [pps_pkg::MaxTasks],
  output pps_pkg::time_t   arrivals_o   [pps_pkg::MaxTasks],
  output pps_pkg::time_t   bursts_o     [pps_pkg::MaxTasks],
  output pps_pkg::time_t   remaining_o  [pps_pkg::MaxTasks],
  output pps_pkg::prio_t   priorities_o [pps_pkg::MaxTasks]
);

  pps_pkg::id_t   ids_q        [pps_pkg::MaxTasks];
  pps_pkg::time_t arrivals_q   [pps_pkg::MaxTasks];
  pps_pkg::time_t bursts_q     [pps_pkg::MaxTasks];
  pps_pkg::time_t remaining_q  [pps_pkg::MaxTasks];
  pps_pkg::prio_t priorities_q [pps_pkg::MaxTasks];

  // static task data, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.load) begin
      ids_q[wr_i.load_idx]        <= wr_i.id;
      arrivals_q[wr_i.load_idx]   <= wr_i.arrival;
      bursts_q[wr_i.load_idx]     <= wr_i.burst;
      priorities_q[wr_i.load_idx] <= wr_i.prio;
    end
  end

  // remaining work resets to zero so unloaded slots are never picked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pps_pkg::MaxTasks; k++) begin
        remaining_q[k] <= '0;
      end
    end else if (wr_i.load) begin
      remaining_q[wr_i.load_idx] <= wr_i.burst;
    end else if (wr_i.dec) begin
      remaining_q[wr_i.dec_idx] <= remaining_q[wr_i.dec_idx] - 1'b1;
    end
  end

  assign ids_o        = ids_q;
  assign arrivals_o   = arrivals_q;
  assign bursts_o     = bursts_q;
  assign remaining_o  = remaining_q;
  assign priorities_o = priorities_q;

endmodule

### rtl/pps_pick.sv
// Eligibility masks and min-priority tree; also the post-tick all-done flag.
module pps_pick (
  input  pps_pkg::count_t task_count_i,
  input  pps_pkg::time_t  now_i,
  input  pps_pkg::time_t  arrivals_i   [pps_pkg::MaxTasks],
  input  pps_pkg::time_t  remaining_i  [pps_pkg::MaxTasks],
  input  pps_pkg::prio_t  priorities_i [pps_pkg::MaxTasks],
  output pps_pkg::pick_t  pick_o
);

  localparam int KeyW  = 1 + pps_pkg::PrioW + pps_pkg::IdxW;
  localparam int Nodes = 2 * pps_pkg::MaxTasks - 1;

  typedef logic [KeyW-1:0] key_t;

  logic [pps_pkg::MaxTasks-1:0] in_use;
  logic [pps_pkg::MaxTasks-1:0] busy_after;
  key_t                         node [Nodes];
  logic                         ran;
  pps_pkg::idx_t                idx;

  // key = {not eligible, priority, slot}: smallest key wins, ties to low slot
  always_comb begin
    for (int k = 0; k < pps_pkg::MaxTasks; k++) begin
      in_use[k] = int'(task_count_i) > k;
      node[pps_pkg::MaxTasks - 1 + k] = {
        ~(in_use[k] && (remaining_i[k] != '0) && (arrivals_i[k] <= now_i)),
        priorities_i[k],
        pps_pkg::idx_t'(k)
      };
    end
    for (int i = pps_pkg::MaxTasks - 2; i >= 0; i--) begin
      node[i] = (node[2*i+1] <= node[2*i+2]) ? node[2*i+1] : node[2*i+2];
    end
  end

  assign ran = ~node[0][KeyW-1];
  assign idx = node[0][pps_pkg::IdxW-1:0];

  // work left after this tick's decrement
  always_comb begin
    for (int k = 0; k < pps_pkg::MaxTasks; k++) begin
      busy_after[k] = in_use[k] && (remaining_i[k] != '0) &&
                      !(ran && (idx == pps_pkg::idx_t'(k)) &&
                        (remaining_i[k] == pps_pkg::time_t'(1)));
    end
  end

  assign pick_o.ran      = ran;
  assign pick_o.idx      = idx;
  assign pick_o.all_done = ~|busy_after;

endmodule

### rtl/preemptive_priority_scheduler.sv
// Each word waits in the input register; a tick then registers its result word for output.
// One word per cycle unless a tick stalls on the output; the min-priority tree over all slots is combinational.
// Load words produce no result; tick words produce exactly one result word.
// Reset (rst_ni low, async): clears time, task_count, remaining work and both valid flags.
// Task ids, arrivals, bursts and priorities hold garbage until loaded.
module preemptive_priority_scheduler (
  input  logic      clk_i,
  input  logic      rst_ni,
  pps_in_if.sink    in_i,
  pps_out_if.source out_o,
  pps_cfg_if.sink   cfg_i
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic               s1_valid_q, s1_valid_d;
  pps_pkg::in_word_t  s1_word_q;
  pps_pkg::time_t     now_q, now_d;
  pps_pkg::count_t    count_q;
  logic               out_valid_q, out_valid_d;
  pps_pkg::out_word_t out_word_q, out_word_d;

  // ---------------------------------------------------------------------------
  // Table and selection
  // ---------------------------------------------------------------------------
  pps_pkg::tbl_wr_t tbl_wr;
  pps_pkg::id_t     ids        [pps_pkg::MaxTasks];
  pps_pkg::time_t   arrivals   [pps_pkg::MaxTasks];
  pps_pkg::time_t   bursts     [pps_pkg::MaxTasks];
  pps_pkg::time_t   remaining  [pps_pkg::MaxTasks];
  pps_pkg::prio_t   priorities [pps_pkg::MaxTasks];
  pps_pkg::pick_t   pick;

  logic             is_tick;
  logic             s1_fire;
  logic             slot_ok;
  pps_pkg::time_t   finish;
  pps_pkg::time_t   turnaround;
  logic             completed;

  pps_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (tbl_wr),
    .ids_o        (ids),
    .arrivals_o   (arrivals),
    .bursts_o     (bursts),
    .remaining_o  (remaining),
    .priorities_o (priorities)
  );

  pps_pick u_pick (
    .task_count_i (count_q),
    .now_i        (now_q),
    .arrivals_i   (arrivals),
    .remaining_i  (remaining),
    .priorities_i (priorities),
    .pick_o       (pick)
  );

  // ---------------------------------------------------------------------------
  // Handshake
  // A load never blocks on the output; a tick needs the result register free
  // or draining this cycle. The input register takes a new word whenever its
  // current word leaves.
  // ---------------------------------------------------------------------------
  assign is_tick  = (s1_word_q.cmd == pps_pkg::CmdTick);
  assign s1_fire  = s1_valid_q && (!is_tick || !out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_fire;
  assign cfg_i.ready = 1'b1;

  assign s1_valid_d = in_i.ready ? in_i.valid : s1_valid_q;

  // ---------------------------------------------------------------------------
  // Table writes: loads outside the table are dropped
  // ---------------------------------------------------------------------------
  assign slot_ok = int'(s1_word_q.slot) < pps_pkg::MaxTasks;

  always_comb begin
    tbl_wr          = '0;
    tbl_wr.load     = s1_fire && !is_tick && slot_ok;
    tbl_wr.load_idx = pps_pkg::idx_t'(s1_word_q.slot);
    tbl_wr.id       = s1_word_q.task_id;
    tbl_wr.arrival  = s1_word_q.arrival_time;
    tbl_wr.burst    = s1_word_q.burst_length;
    tbl_wr.prio     = s1_word_q.task_priority;
    tbl_wr.dec      = s1_fire && is_tick && pick.ran;
    tbl_wr.dec_idx  = pick.idx;
  end

  // ---------------------------------------------------------------------------
  // Tick result
  // Time saturates at all ones. Waiting clamps at zero, which only matters
  // once the time has saturated.
  // ---------------------------------------------------------------------------
  assign finish     = (now_q == '1) ? now_q : now_q + 1'b1;
  assign turnaround = finish - arrivals[pick.idx];
  assign completed  = pick.ran && (remaining[pick.idx] == pps_pkg::time_t'(1));

  always_comb begin
    out_word_d           = '0;
    out_word_d.tick_time = finish;
    out_word_d.all_done  = pick.all_done;
    if (pick.ran) begin
      out_word_d.ran    = 1'b1;
      out_word_d.run_id = ids[pick.idx];
    end
    if (completed) begin
      out_word_d.completed  = 1'b1;
      out_word_d.finish_at  = finish;
      out_word_d.turnaround = turnaround;
      out_word_d.waiting    = (turnaround >= bursts[pick.idx]) ?
                              turnaround - bursts[pick.idx] : '0;
    end
  end

  assign now_d = (s1_fire && is_tick) ? finish : now_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && is_tick) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequential
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      now_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        count_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_word_q <= in_i.data;
    end
    if (s1_fire && is_tick) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule
